// ===== rtl/spl_pkg.sv =====
// ----------------------------------------------------------------------------
// spl_pkg
// Shared types and codes for the stable priority list.
// ----------------------------------------------------------------------------
`default_nettype none

package spl_pkg;

  localparam int STATUS_BITS = 3;

  localparam logic [STATUS_BITS-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL       = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY_NAME = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_LIST_EMPTY = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND  = 3'd4;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  // classification made by the front end for each queued word
  typedef struct packed {
    logic is_delete;
    logic name_zero;
  } cmd_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/spl_front.sv =====
// ----------------------------------------------------------------------------
// spl_front
// Input side: takes request words, classifies them and holds them in a
// two-entry queue for the list engine.
// ----------------------------------------------------------------------------
`default_nettype none

module spl_front #(
  parameter int PRIORITY_BITS = 8,
  parameter int NAME_BITS     = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire                      kind,
  input  wire  [PRIORITY_BITS-1:0] priority_req,
  input  wire  [NAME_BITS-1:0]     name_key,
  output logic                     cmd_valid,
  input  wire                      cmd_ready,
  output spl_pkg::cmd_ctrl_t       cmd_ctrl,
  output logic [PRIORITY_BITS-1:0] cmd_prio,
  output logic [NAME_BITS-1:0]     cmd_name
);

  localparam int QDEPTH = 2;

  spl_pkg::cmd_ctrl_t       q_ctrl [QDEPTH];
  logic [PRIORITY_BITS-1:0] q_prio [QDEPTH];
  logic [NAME_BITS-1:0]     q_name [QDEPTH];
  logic                     wr_ptr;
  logic                     rd_ptr;
  logic [1:0]               q_count;
  logic                     push;
  logic                     pop;
  spl_pkg::cmd_ctrl_t       in_ctrl;

  assign in_ready  = (q_count != 2'(QDEPTH));
  assign cmd_valid = (q_count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    in_ctrl.is_delete = (kind == spl_pkg::KIND_DELETE);
    in_ctrl.name_zero = (name_key == '0);
  end

  assign cmd_ctrl = q_ctrl[rd_ptr];
  assign cmd_prio = q_prio[rd_ptr];
  assign cmd_name = q_name[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        q_count <= q_count + 2'd1;
      end else if (pop && !push) begin
        q_count <= q_count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_ctrl[wr_ptr] <= in_ctrl;
      q_prio[wr_ptr] <= priority_req;
      q_name[wr_ptr] <= name_key;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spl_back.sv =====
// ----------------------------------------------------------------------------
// spl_back
// List engine: a row of entry cells kept in priority order. Insert is one
// compare-and-shift step; delete drops one match per cycle when out_free.
// ----------------------------------------------------------------------------
`default_nettype none

module spl_back #(
  parameter int MAX_ENTRIES   = 16,
  parameter int PRIORITY_BITS = 8,
  parameter int NAME_BITS     = 32,
  localparam int CW           = $clog2(MAX_ENTRIES + 1)
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cmd_valid,
  output logic                               cmd_ready,
  input  wire  spl_pkg::cmd_ctrl_t           cmd_ctrl,
  input  wire  [PRIORITY_BITS-1:0]           cmd_prio,
  input  wire  [NAME_BITS-1:0]               cmd_name,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [spl_pkg::STATUS_BITS-1:0]    status,
  output logic [CW-1:0]                      entry_count,
  output logic [PRIORITY_BITS-1:0]           head_priority,
  output logic [NAME_BITS-1:0]               head_name
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                     state;
  logic                     state_next;
  spl_pkg::cmd_ctrl_t       op_ctrl;
  logic [PRIORITY_BITS-1:0] op_prio;
  logic [NAME_BITS-1:0]     op_name;
  logic                     found;
  logic                     found_next;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;

  logic [PRIORITY_BITS-1:0] ent_prio      [MAX_ENTRIES];
  logic [NAME_BITS-1:0]     ent_name      [MAX_ENTRIES];
  logic [PRIORITY_BITS-1:0] ent_prio_next [MAX_ENTRIES];
  logic [NAME_BITS-1:0]     ent_name_next [MAX_ENTRIES];
  logic [PRIORITY_BITS-1:0] ent_prio_dn   [MAX_ENTRIES];
  logic [NAME_BITS-1:0]     ent_name_dn   [MAX_ENTRIES];
  logic [PRIORITY_BITS-1:0] ent_prio_up   [MAX_ENTRIES];
  logic [NAME_BITS-1:0]     ent_name_up   [MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0]   gtv;
  logic [MAX_ENTRIES-1:0]   gt_prev;
  logic [MAX_ENTRIES-1:0]   match;
  logic [MAX_ENTRIES-1:0]   upto;
  logic                     any_match;

  logic                     pop;
  logic                     out_free;
  logic                     res_we;
  logic [spl_pkg::STATUS_BITS-1:0] res_status;

  assign cmd_ready = (state == S_IDLE);
  assign pop       = cmd_valid && cmd_ready;
  assign out_free  = !out_valid || out_ready;

  // neighbor taps for the shift network
  assign ent_prio_dn[0] = ent_prio[0];
  assign ent_name_dn[0] = ent_name[0];
  assign ent_prio_up[MAX_ENTRIES-1] = ent_prio[MAX_ENTRIES-1];
  assign ent_name_up[MAX_ENTRIES-1] = ent_name[MAX_ENTRIES-1];

  for (genvar g = 1; g < MAX_ENTRIES; g++) begin : g_taps
    assign ent_prio_dn[g]   = ent_prio[g-1];
    assign ent_name_dn[g]   = ent_name[g-1];
    assign ent_prio_up[g-1] = ent_prio[g];
    assign ent_name_up[g-1] = ent_name[g];
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cells
    assign gtv[g]   = (CW'(g) < count) && (ent_prio[g] > op_prio);
    assign match[g] = (CW'(g) < count) && (ent_name[g] == op_name);
    // set at and above the first match: those cells pull from above
    assign upto[g]  = |match[g:0];
  end

  assign gt_prev   = {gtv[MAX_ENTRIES-2:0], 1'b0};
  assign any_match = upto[MAX_ENTRIES-1];

  always_comb begin
    state_next = state;
    found_next = found;
    count_next = count;
    res_we     = 1'b0;
    res_status = spl_pkg::ST_OK;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ent_prio_next[i] = ent_prio[i];
      ent_name_next[i] = ent_name[i];
    end

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_EXEC;
          found_next = 1'b0;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          if (!op_ctrl.is_delete) begin
            res_we     = 1'b1;
            state_next = S_IDLE;
            if (count == CW'(MAX_ENTRIES)) begin
              res_status = spl_pkg::ST_FULL;
            end else if (op_ctrl.name_zero) begin
              res_status = spl_pkg::ST_EMPTY_NAME;
            end else begin
              // new word lands after every entry of equal or lower priority
              for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (gt_prev[i]) begin
                  ent_prio_next[i] = ent_prio_dn[i];
                  ent_name_next[i] = ent_name_dn[i];
                end else if (gtv[i] || (CW'(i) == count)) begin
                  ent_prio_next[i] = op_prio;
                  ent_name_next[i] = op_name;
                end
              end
              count_next = count + CW'(1);
              res_status = spl_pkg::ST_OK;
            end
          end else begin
            if (!found && count == '0) begin
              res_we     = 1'b1;
              state_next = S_IDLE;
              res_status = spl_pkg::ST_LIST_EMPTY;
            end else if (op_ctrl.name_zero) begin
              res_we     = 1'b1;
              state_next = S_IDLE;
              res_status = spl_pkg::ST_EMPTY_NAME;
            end else if (any_match) begin
              for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (upto[i]) begin
                  ent_prio_next[i] = ent_prio_up[i];
                  ent_name_next[i] = ent_name_up[i];
                end
              end
              count_next = count - CW'(1);
              found_next = 1'b1;
            end else begin
              res_we     = 1'b1;
              state_next = S_IDLE;
              res_status = found ? spl_pkg::ST_OK : spl_pkg::ST_NOT_FOUND;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      found     <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      found <= found_next;
      count <= count_next;
      if (res_we) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ent_prio[i] <= ent_prio_next[i];
      ent_name[i] <= ent_name_next[i];
    end
    if (pop) begin
      op_ctrl <= cmd_ctrl;
      op_prio <= cmd_prio;
      op_name <= cmd_name;
    end
    if (res_we) begin
      status      <= res_status;
      entry_count <= count_next;
      if (count_next != '0) begin
        head_priority <= ent_prio_next[0];
        head_name     <= ent_name_next[0];
      end else begin
        head_priority <= '0;
        head_name     <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/stable_priority_list.sv =====
// ----------------------------------------------------------------------------
// stable_priority_list
// Sorted list of priority/name entries with stable insert and delete-by-name.
//
//   channel  signals                                   dir
//   in       in_valid in_ready kind priority_req name_key    in
//   out      out_valid out_ready status entry_count
//            head_priority head_name                   out
//
// A request word accepted into the front queue is taken by the list engine
// when the engine is idle, and its result word is registered from the
// execute state once the output is free. The engine works one word at a
// time (take, then execute); a delete stays in execute and removes one
// matching entry per cycle, while the output is free, until none is left.
// rst is synchronous and clears the queue, engine state, count and out_valid.
// A stalled out_ready holds the engine; the front queue still takes two words.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_list #(
  parameter int MAX_ENTRIES   = 16,
  parameter int PRIORITY_BITS = 8,
  parameter int NAME_BITS     = 32
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  kind,
  input  wire  [PRIORITY_BITS-1:0]             priority_req,
  input  wire  [NAME_BITS-1:0]                 name_key,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [spl_pkg::STATUS_BITS-1:0]      status,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]     entry_count,
  output logic [PRIORITY_BITS-1:0]             head_priority,
  output logic [NAME_BITS-1:0]                 head_name
);

  logic                     cmd_valid;
  logic                     cmd_ready;
  spl_pkg::cmd_ctrl_t       cmd_ctrl;
  logic [PRIORITY_BITS-1:0] cmd_prio;
  logic [NAME_BITS-1:0]     cmd_name;

  spl_front #(
    .PRIORITY_BITS (PRIORITY_BITS),
    .NAME_BITS     (NAME_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .priority_req (priority_req),
    .name_key     (name_key),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd_ctrl     (cmd_ctrl),
    .cmd_prio     (cmd_prio),
    .cmd_name     (cmd_name)
  );

  spl_back #(
    .MAX_ENTRIES   (MAX_ENTRIES),
    .PRIORITY_BITS (PRIORITY_BITS),
    .NAME_BITS     (NAME_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd_ctrl      (cmd_ctrl),
    .cmd_prio      (cmd_prio),
    .cmd_name      (cmd_name),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .entry_count   (entry_count),
    .head_priority (head_priority),
    .head_name     (head_name)
  );

endmodule

`default_nettype wire
